// ===== rtl/hlm_pkg.sv =====
// shared types, constants and register indexes for the heartbeat link monitor
package hlm_pkg;

   localparam int unsigned NOW_W      = 64;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned TIMEOUT_W  = PERIOD_W + COUNT_W;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_MS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MISS_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVER_COUNT = 2'd2;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd1000;
   localparam logic [COUNT_W-1:0]   MISS_RESET    = 8'd6;
   localparam logic [COUNT_W-1:0]   RECOVER_RESET = 8'd2;
   localparam logic [COUNT_W-1:0]   STREAK_MAX    = 8'd255;

   typedef enum logic {
      CMD_TICK      = 1'b0,
      CMD_HEARTBEAT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      EVENT_NONE = 2'd0,
      EVENT_UP   = 2'd1,
      EVENT_DOWN = 2'd2
   } event_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]  period_ms;
      logic [COUNT_W-1:0]   miss_limit;
      logic [COUNT_W-1:0]   recover_count;
      logic [TIMEOUT_W-1:0] timeout_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type          command;
      logic [NOW_W-1:0] now_ms;
      logic             connected;
   } item_type;

   typedef struct packed {
      logic               link_up;
      event_type          link_event;
      logic [STAMP_W-1:0] event_time;
      logic               send_heartbeat;
      logic [SEQ_W-1:0]   heartbeat_seq;
   } result_type;

endpackage

// ===== rtl/hlm_cfg_regs.sv =====
// configuration registers and the registered timeout product
module hlm_cfg_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [hlm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hlm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hlm_pkg::cfg_type              cfg
);
   import hlm_pkg::*;

   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [COUNT_W-1:0]   miss_ff, miss_in;
   logic [COUNT_W-1:0]   recover_ff, recover_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   always_comb begin
      period_in  = period_ff;
      miss_in    = miss_ff;
      recover_in = recover_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PERIOD_MS:     period_in  = csr_wdata;
            REG_MISS_LIMIT:    miss_in    = csr_wdata[COUNT_W-1:0];
            REG_RECOVER_COUNT: recover_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // product is registered from the stored period and miss limit, so it updates after them
   assign timeout_in = TIMEOUT_W'(period_ff) * TIMEOUT_W'(miss_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         miss_ff    <= MISS_RESET;
         recover_ff <= RECOVER_RESET;
         timeout_ff <= TIMEOUT_W'(PERIOD_RESET) * TIMEOUT_W'(MISS_RESET);
      end else begin
         period_ff  <= period_in;
         miss_ff    <= miss_in;
         recover_ff <= recover_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg = '{period_ms: period_ff, miss_limit: miss_ff,
                  recover_count: recover_ff, timeout_ms: timeout_ff};

endmodule

// ===== rtl/hlm_in_reg.sv =====
// input register stage for request beats
module hlm_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hlm_pkg::item_type in_item,
   input  logic              advance,
   output logic              hold_valid,
   output hlm_pkg::item_type hold_item
);
   import hlm_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

// ===== rtl/hlm_core.sv =====
// link state, heartbeat sender and result register
module hlm_core (
   input  logic                clock,
   input  logic                reset,
   input  hlm_pkg::cfg_type    cfg,
   input  logic                hold_valid,
   input  hlm_pkg::item_type   hold_item,
   output logic                advance,
   input  logic                out_ready,
   output logic                out_valid,
   output hlm_pkg::result_type out_result
);
   import hlm_pkg::*;

   logic               is_up_ff, is_up_in;
   logic               host_seen_ff, host_seen_in;
   logic [NOW_W-1:0]   last_host_ff, last_host_in;
   logic [COUNT_W-1:0] streak_ff, streak_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [NOW_W-1:0]   last_send_ff, last_send_in;
   logic               valid_ff, valid_in;
   result_type         result_ff, result_in;

   logic [NOW_W-1:0]   since_send;
   logic [NOW_W-1:0]   since_host;
   logic [COUNT_W-1:0] streak_inc;
   logic               fire;
   event_type          event_code;
   logic               send;

   assign advance = !valid_ff || out_ready;
   assign fire    = hold_valid && advance;

   assign since_send = hold_item.now_ms - last_send_ff;
   assign since_host = hold_item.now_ms - last_host_ff;
   assign streak_inc = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + 8'd1;

   always_comb begin
      is_up_in     = is_up_ff;
      host_seen_in = host_seen_ff;
      last_host_in = last_host_ff;
      streak_in    = streak_ff;
      seq_in       = seq_ff;
      last_send_in = last_send_ff;
      event_code   = EVENT_NONE;
      send         = 1'b0;
      unique case (hold_item.command)
         CMD_HEARTBEAT: begin
            last_host_in = hold_item.now_ms;
            host_seen_in = 1'b1;
            streak_in    = streak_inc;
            if (!is_up_ff && streak_inc >= cfg.recover_count) begin
               is_up_in   = 1'b1;
               streak_in  = '0;
               event_code = EVENT_UP;
            end
         end
         CMD_TICK: begin
            if (hold_item.connected && since_send >= NOW_W'(cfg.period_ms)) begin
               last_send_in = hold_item.now_ms;
               seq_in       = seq_ff + 32'd1;
               send         = 1'b1;
            end
            if (host_seen_ff && is_up_ff && since_host > NOW_W'(cfg.timeout_ms)) begin
               is_up_in   = 1'b0;
               streak_in  = '0;
               event_code = EVENT_DOWN;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result_in.link_up        = is_up_in;
      result_in.link_event     = event_code;
      result_in.event_time     = (event_code != EVENT_NONE) ?
                                 hold_item.now_ms[STAMP_W-1:0] : '0;
      result_in.send_heartbeat = send;
      result_in.heartbeat_seq  = seq_in;
   end

   always_comb begin
      priority if (fire) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_up_ff     <= 1'b0;
         host_seen_ff <= 1'b0;
         last_host_ff <= '0;
         streak_ff    <= '0;
         seq_ff       <= '0;
         last_send_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (fire) begin
            is_up_ff     <= is_up_in;
            host_seen_ff <= host_seen_in;
            last_host_ff <= last_host_in;
            streak_ff    <= streak_in;
            seq_ff       <= seq_in;
            last_send_ff <= last_send_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/heartbeat_link_monitor.sv =====
// heartbeat link monitor top level
// path: a request beat is held in the input register, then the core registers its response
// throughput: one beat per cycle unless the response side stalls; the core updates the link state as each beat fires
// the timeout product is registered from the period and miss limit registers, so it settles after them
// reset: synchronous, clears link state, sequence, time stamps and valids, loads configuration defaults
module heartbeat_link_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [63:0] now_ms, [64] connected, [71:65] zero
   input  logic [hlm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] link_up, [2:1] link_event, [34:3] event_time, [35] send_heartbeat,
   // [67:36] heartbeat_seq, [71:68] zero
   output logic [hlm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [hlm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hlm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hlm_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   hold_item;
   logic       hold_valid;
   logic       advance;
   result_type result;

   assign req_item = '{command: cmd_type'(req_tuser),
                       now_ms: req_tdata[NOW_W-1:0],
                       connected: req_tdata[NOW_W]};

   hlm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hlm_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   hlm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .advance    (advance),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (result)
   );

   assign rsp_tdata = {4'd0, result.heartbeat_seq, result.send_heartbeat,
                       result.event_time, 2'(result.link_event), result.link_up};

endmodule

// ===== rtl/hlm_checker.sv =====
// port level checks for the heartbeat link monitor, bound to the top level
module hlm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hlm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hlm_pkg::*;

   logic [1:0] rsp_event;
   assign rsp_event = rsp_tdata[2:1];

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // no response beat straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a response from an empty output comes from a request beat taken through the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response beat without a request beat");

   // event code agrees with the link flag and the time stamp
   a_event_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_event == EVENT_NONE && rsp_tdata[34:3] == '0) ||
          (rsp_event == EVENT_UP && rsp_tdata[0]) ||
          (rsp_event == EVENT_DOWN && !rsp_tdata[0])))
      else $error("link event inconsistent with link flag");

endmodule

bind heartbeat_link_monitor hlm_checker u_hlm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
